FILE: design/prst_pkg.sv
// ----------------------------------------------------------------------------
// prst_pkg: shared types and constants of the request slot table
// Slot count, command and status codes, and field widths.
// ----------------------------------------------------------------------------
package prst_pkg;
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MAX_OUT = 16;
  localparam logic [15:0] NO_SLOT = 16'hffff;
  localparam logic [31:0] BYTES_MAX = 32'hffff_ffff;

  typedef enum logic [2:0] {
    CMD_SUBMIT   = 3'd0,
    CMD_CLAIM    = 3'd1,
    CMD_PROGRESS = 3'd2,
    CMD_FINISH   = 3'd3,
    CMD_CANCEL   = 3'd4,
    CMD_RELEASE  = 3'd5,
    CMD_QUERY    = 3'd6,
    CMD_DISPATCH = 3'd7
  } cmd_t;

  localparam logic [2:0] ST_UNUSED    = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_READING   = 3'd2;
  localparam logic [2:0] ST_READY     = 3'd3;
  localparam logic [2:0] ST_FAILED    = 3'd4;
  localparam logic [2:0] ST_CANCELLED = 3'd5;

  localparam logic [2:0] RC_OK        = 3'd0;
  localparam logic [2:0] RC_SHORT     = 3'd4;
  localparam logic [2:0] RC_CANCELLED = 3'd5;
endpackage

FILE: design/prioritized_request_slot_table_unit.sv
// ----------------------------------------------------------------------------
// prioritized_request_slot_table_unit: generation-tagged request slot table
// Commands submit, claim, progress, finish, cancel, release, query, dispatch.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one command beat; output channel
// out_valid/out_ready carries result beats. Every command yields one result
// beat with last set, except dispatch, which yields one beat per pending
// completion (up to MAX_OUT, index order) and sets last on the final one.
// Submit and claim walk the slot table one slot per cycle under a small
// sequencer, then update the chosen slot and register their result beat.
// Dispatch walks the same way, but pauses at each further pending slot until
// the held beat before it is delivered. Handle commands look up their slot,
// apply the update and then register their result beat.
// The scan compare/select unit is the rate limit.
// The block takes no new command until the last result beat is delivered;
// the next command beat is taken in the cycle after that. A stalled receiver
// holds the output register and the sequencer.
// Reset clears every slot, the enable register and the sequencer at once.
// Configuration: cfg_we writes cfg_wdata into the enable register.
// ----------------------------------------------------------------------------
module prioritized_request_slot_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [15:0] slot_index,
  input  logic [15:0] handle_generation,
  input  logic [31:0] req_offset,
  input  logic [31:0] req_size,
  input  logic [2:0]  priority_req,
  input  logic [31:0] user_tag,
  input  logic [16:0] byte_count,
  input  logic [1:0]  io_outcome,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [15:0] out_slot,
  output logic [15:0] out_generation,
  output logic [2:0]  out_status,
  output logic [2:0]  result_code,
  output logic [31:0] bytes_done,
  output logic [31:0] out_tag,
  output logic [31:0] out_offset,
  output logic [31:0] out_size,
  output logic        abort_transfer,
  output logic        last
);
  import prst_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_DISP, S_DONE, S_OUT} state_t;

  state_t state;
  logic enabled;
  logic [SLOTS-1:0] s_used, s_pend;
  logic [15:0] s_gen [SLOTS];
  logic [31:0] s_off [SLOTS], s_size [SLOTS], s_bytes [SLOTS], s_tag [SLOTS];
  logic [2:0]  s_pri [SLOTS], s_stat [SLOTS], s_res [SLOTS], s_evst [SLOTS];

  cmd_t        cmd;
  logic [15:0] c_idx, c_gen;
  logic [31:0] c_off, c_size, c_tag;
  logic [2:0]  c_pri;
  logic [16:0] c_cnt;
  logic [1:0]  c_oc;

  logic [CNT_W-1:0] ptr;
  logic [IDX_W-1:0] ip;
  logic             best_ok;
  logic [IDX_W-1:0] best;
  logic [2:0]       best_pri;
  logic [CNT_W-1:0] nout;
  logic             back_to_scan;

  logic             hit;
  logic [IDX_W-1:0] hidx;
  logic [32:0]      sum;

  assign in_ready = (state == S_IDLE);
  assign ip = ptr[IDX_W-1:0];
  assign hidx = c_idx[IDX_W-1:0];
  assign hit = (c_idx < 16'(SLOTS)) && s_used[hidx] && (s_gen[hidx] == c_gen);
  assign sum = {1'b0, s_bytes[hidx]} + {16'd0, c_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      enabled <= 1'b0;
      out_valid <= 1'b0;
      s_used <= '0;
      s_pend <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        s_gen[k] <= '0; s_off[k] <= '0; s_size[k] <= '0; s_bytes[k] <= '0;
        s_tag[k] <= '0; s_pri[k] <= '0; s_stat[k] <= ST_UNUSED; s_res[k] <= '0;
        s_evst[k] <= '0;
      end
    end else begin
      if (cfg_we) enabled <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= cmd_t'(command);
            c_idx <= slot_index; c_gen <= handle_generation;
            c_off <= req_offset; c_size <= req_size; c_pri <= priority_req;
            c_tag <= user_tag; c_cnt <= byte_count; c_oc <= io_outcome;
            ptr <= '0; best_ok <= 1'b0; best <= '0; best_pri <= '0; nout <= '0;
            case (cmd_t'(command))
              CMD_SUBMIT, CMD_CLAIM: state <= S_SCAN;
              CMD_DISPATCH:          state <= S_DISP;
              default:               state <= S_APPLY;
            endcase
          end
        end
        S_SCAN: begin
          // one slot per cycle through the shared compare/select
          if (ptr == CNT_W'(SLOTS)) begin
            state <= S_APPLY;
          end else begin
            if (cmd == CMD_SUBMIT) begin
              if (!best_ok && !s_used[ip]) begin best_ok <= 1'b1; best <= ip; end
            end else if (s_used[ip] && s_stat[ip] == ST_QUEUED &&
                         (!best_ok || s_pri[ip] > best_pri)) begin
              best_ok <= 1'b1; best <= ip; best_pri <= s_pri[ip];
            end
            ptr <= ptr + 1'b1;
          end
        end
        S_DISP: begin
          if (!enabled || ptr == CNT_W'(SLOTS) || nout == CNT_W'(MAX_OUT)) begin
            if (nout == '0) begin
              found <= 1'b0; out_slot <= NO_SLOT; out_generation <= '0;
              out_status <= '0; result_code <= '0; bytes_done <= '0; out_tag <= '0;
              out_offset <= '0; out_size <= '0; abort_transfer <= 1'b0;
              last <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
            end else begin
              // flag the held beat as final
              last <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
              back_to_scan <= 1'b0;
            end
          end else if (s_used[ip] && s_pend[ip]) begin
            if (nout != '0) begin
              // emit previous beat, then continue
              out_valid <= 1'b1; last <= 1'b0; state <= S_OUT; back_to_scan <= 1'b1;
            end else begin
              found <= 1'b1; out_slot <= 16'(ip); out_generation <= s_gen[ip];
              out_status <= s_evst[ip]; result_code <= s_res[ip];
              bytes_done <= s_bytes[ip]; out_tag <= s_tag[ip];
              out_offset <= s_off[ip]; out_size <= s_size[ip];
              abort_transfer <= 1'b0; s_pend[ip] <= 1'b0;
              nout <= nout + 1'b1; ptr <= ptr + 1'b1;
            end
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (cmd == CMD_DISPATCH && !last && back_to_scan) begin
              found <= 1'b1; out_slot <= 16'(ip); out_generation <= s_gen[ip];
              out_status <= s_evst[ip]; result_code <= s_res[ip];
              bytes_done <= s_bytes[ip]; out_tag <= s_tag[ip];
              out_offset <= s_off[ip]; out_size <= s_size[ip];
              s_pend[ip] <= 1'b0; nout <= nout + 1'b1; ptr <= ptr + 1'b1;
              state <= S_DISP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_APPLY: begin
          state <= S_DONE;
          if (cmd == CMD_SUBMIT) begin
            if (enabled && c_size != '0 && best_ok) begin
              s_used[best] <= 1'b1;
              s_gen[best] <= (s_gen[best] == 16'hffff) ? 16'd1 : s_gen[best] + 16'd1;
              s_off[best] <= c_off; s_size[best] <= c_size; s_pri[best] <= c_pri;
              s_tag[best] <= c_tag; s_stat[best] <= ST_QUEUED; s_bytes[best] <= '0;
              s_res[best] <= '0; s_pend[best] <= 1'b0; s_evst[best] <= '0;
            end else begin
              best_ok <= 1'b0;
            end
          end else if (cmd == CMD_CLAIM) begin
            if (best_ok) begin
              s_stat[best] <= ST_READING; s_bytes[best] <= '0; s_res[best] <= '0;
            end
          end else if (hit) begin
            best_ok <= 1'b1; best <= hidx;
            case (cmd)
              CMD_PROGRESS:
                if (s_stat[hidx] == ST_READING)
                  s_bytes[hidx] <= sum[32] ? BYTES_MAX : sum[31:0];
              CMD_FINISH:
                if (s_stat[hidx] == ST_READING) begin
                  s_pend[hidx] <= 1'b1;
                  if (c_oc != 2'd0) begin
                    s_stat[hidx] <= ST_FAILED; s_evst[hidx] <= ST_FAILED;
                    s_res[hidx] <= {1'b0, c_oc};
                  end else if (s_bytes[hidx] == s_size[hidx]) begin
                    s_stat[hidx] <= ST_READY; s_evst[hidx] <= ST_READY;
                    s_res[hidx] <= RC_OK;
                  end else begin
                    s_stat[hidx] <= ST_FAILED; s_evst[hidx] <= ST_FAILED;
                    s_res[hidx] <= RC_SHORT;
                  end
                end
              CMD_CANCEL:
                if (s_stat[hidx] != ST_READY && s_stat[hidx] != ST_FAILED &&
                    s_stat[hidx] != ST_CANCELLED) begin
                  s_pend[hidx] <= 1'b1; s_stat[hidx] <= ST_CANCELLED;
                  s_evst[hidx] <= ST_CANCELLED; s_res[hidx] <= RC_CANCELLED;
                end
              CMD_RELEASE:
                if (s_stat[hidx] != ST_READING) begin
                  s_used[hidx] <= 1'b0; s_off[hidx] <= '0; s_size[hidx] <= '0;
                  s_pri[hidx] <= '0; s_stat[hidx] <= ST_UNUSED; s_bytes[hidx] <= '0;
                  s_res[hidx] <= '0; s_pend[hidx] <= 1'b0; s_evst[hidx] <= '0;
                  s_tag[hidx] <= '0;
                end
              default: ;
            endcase
          end else begin
            best_ok <= 1'b0;
          end
        end
        S_DONE: begin
          // report the slot after its update
          found <= best_ok; last <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
          abort_transfer <= (cmd == CMD_PROGRESS) &&
                            (!best_ok || s_stat[best] == ST_CANCELLED);
          if (best_ok) begin
            out_slot <= 16'(best); out_generation <= s_gen[best];
            out_status <= s_stat[best]; result_code <= s_res[best];
            bytes_done <= s_bytes[best]; out_tag <= s_tag[best];
            out_offset <= s_off[best]; out_size <= s_size[best];
          end else begin
            out_slot <= NO_SLOT; out_generation <= '0; out_status <= '0;
            result_code <= '0; bytes_done <= '0; out_tag <= '0;
            out_offset <= '0; out_size <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: verif/prioritized_request_slot_table_unit_tb.sv
// ----------------------------------------------------------------------------
// prioritized_request_slot_table_unit_tb: self-checking bench for the slot table
// A directed command table, then random command streams with handles drawn
// mostly from live slots. Every result beat is compared with a predicted copy
// of the slot table. Both channels idle at random, and the receiver holds off
// once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module prioritized_request_slot_table_unit_tb;
  import prst_pkg::*;

  typedef struct packed {
    logic        found;
    logic [15:0] slot;
    logic [15:0] gen;
    logic [2:0]  status;
    logic [2:0]  rc;
    logic [31:0] bytes;
    logic [31:0] tag;
    logic [31:0] offset;
    logic [31:0] size;
    logic        abort;
    logic        last;
  } beat_t;

  typedef struct {
    cmd_t        c;
    logic [15:0] idx;
    logic [15:0] gen;
    logic [31:0] offset;
    logic [31:0] size;
    logic [2:0]  pri;
    logic [31:0] tag;
    logic [16:0] cnt;
    logic [1:0]  oc;
    int          set_en;
    bit          typed;
    logic        found;
    logic [15:0] slot;
    logic [2:0]  status;
    logic [2:0]  rc;
  } cmd_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  command;
  logic [15:0] slot_index;
  logic [15:0] handle_generation;
  logic [31:0] req_offset;
  logic [31:0] req_size;
  logic [2:0]  priority_req;
  logic [31:0] user_tag;
  logic [16:0] byte_count;
  logic [1:0]  io_outcome;
  logic        out_valid;
  logic        out_ready;
  logic        found;
  logic [15:0] out_slot;
  logic [15:0] out_generation;
  logic [2:0]  out_status;
  logic [2:0]  result_code;
  logic [31:0] bytes_done;
  logic [31:0] out_tag;
  logic [31:0] out_offset;
  logic [31:0] out_size;
  logic        abort_transfer;
  logic        last;

  prioritized_request_slot_table_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .slot_index(slot_index), .handle_generation(handle_generation),
    .req_offset(req_offset), .req_size(req_size), .priority_req(priority_req),
    .user_tag(user_tag), .byte_count(byte_count), .io_outcome(io_outcome),
    .out_valid(out_valid), .out_ready(out_ready), .found(found),
    .out_slot(out_slot), .out_generation(out_generation), .out_status(out_status),
    .result_code(result_code), .bytes_done(bytes_done), .out_tag(out_tag),
    .out_offset(out_offset), .out_size(out_size),
    .abort_transfer(abort_transfer), .last(last)
  );

  // predicted slot table
  logic        tbl_en;
  logic        tbl_used   [SLOTS];
  logic [15:0] tbl_gen    [SLOTS];
  logic [31:0] tbl_offset [SLOTS];
  logic [31:0] tbl_size   [SLOTS];
  logic [2:0]  tbl_pri    [SLOTS];
  logic [2:0]  tbl_status [SLOTS];
  logic [31:0] tbl_bytes  [SLOTS];
  logic [2:0]  tbl_rc     [SLOTS];
  logic        tbl_pend   [SLOTS];
  logic [2:0]  tbl_evst   [SLOTS];
  logic [31:0] tbl_tag    [SLOTS];

  beat_t    expected_beats[$];
  cmd_row_t cmd_rows[$];
  int       errors = 0;
  bit       calm = 0;
  bit       long_hold = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("prioritized_request_slot_table_unit_tb NOT OK");
    $finish;
  end

  function automatic void push_none(logic ab);
    beat_t b;
    b = '0;
    b.slot = NO_SLOT;
    b.abort = ab;
    b.last = 1'b1;
    expected_beats.push_back(b);
  endfunction

  function automatic void push_slot(int i, logic [2:0] st, logic ab, logic lst);
    beat_t b;
    b.found = 1'b1;
    b.slot = 16'(i);
    b.gen = tbl_gen[i];
    b.status = st;
    b.rc = tbl_rc[i];
    b.bytes = tbl_bytes[i];
    b.tag = tbl_tag[i];
    b.offset = tbl_offset[i];
    b.size = tbl_size[i];
    b.abort = ab;
    b.last = lst;
    expected_beats.push_back(b);
  endfunction

  function automatic void clear_entry(int i);
    tbl_used[i] = 0;
    tbl_offset[i] = '0;
    tbl_size[i] = '0;
    tbl_pri[i] = '0;
    tbl_status[i] = ST_UNUSED;
    tbl_bytes[i] = '0;
    tbl_rc[i] = RC_OK;
    tbl_pend[i] = 0;
    tbl_evst[i] = '0;
    tbl_tag[i] = '0;
  endfunction

  function automatic void post_completion(int i, logic [2:0] st, logic [2:0] rc);
    tbl_status[i] = st;
    tbl_rc[i] = rc;
    tbl_evst[i] = st;
    tbl_pend[i] = 1;
  endfunction

  // apply one command to the predicted table and queue the beats it yields
  function automatic void table_step(cmd_row_t r);
    int    i;
    int    best;
    int    best_pri;
    int    n;
    logic [32:0] sum;
    best = -1;
    best_pri = -1;
    n = 0;
    case (r.c)
      CMD_SUBMIT: begin
        if (tbl_en && r.size != 0)
          for (i = SLOTS - 1; i >= 0; i--)
            if (!tbl_used[i]) best = i;
        if (best < 0) begin
          push_none(0);
        end else begin
          clear_entry(best);
          tbl_gen[best] = tbl_gen[best] + 16'd1;
          if (tbl_gen[best] == 0) tbl_gen[best] = 16'd1;
          tbl_used[best] = 1;
          tbl_offset[best] = r.offset;
          tbl_size[best] = r.size;
          tbl_pri[best] = r.pri;
          tbl_tag[best] = r.tag;
          tbl_status[best] = ST_QUEUED;
          push_slot(best, ST_QUEUED, 0, 1);
        end
      end
      CMD_CLAIM: begin
        for (i = 0; i < SLOTS; i++)
          if (tbl_used[i] && tbl_status[i] == ST_QUEUED && int'(tbl_pri[i]) > best_pri) begin
            best = i;
            best_pri = int'(tbl_pri[i]);
          end
        if (best < 0) begin
          push_none(0);
        end else begin
          tbl_status[best] = ST_READING;
          tbl_bytes[best] = '0;
          tbl_rc[best] = RC_OK;
          push_slot(best, ST_READING, 0, 1);
        end
      end
      CMD_DISPATCH: begin
        if (tbl_en)
          for (i = 0; i < SLOTS && n < MAX_OUT; i++)
            if (tbl_used[i] && tbl_pend[i]) begin
              tbl_pend[i] = 0;
              push_slot(i, tbl_evst[i], 0, 0);
              n++;
            end
        if (n == 0) push_none(0);
        else expected_beats[expected_beats.size() - 1].last = 1'b1;
      end
      default: begin
        if (r.idx >= SLOTS || !tbl_used[r.idx] || tbl_gen[r.idx] != r.gen) begin
          push_none(r.c == CMD_PROGRESS);
        end else begin
          i = int'(r.idx);
          if (r.c == CMD_PROGRESS && tbl_status[i] == ST_CANCELLED) begin
            push_slot(i, ST_CANCELLED, 1, 1);
            return;
          end
          case (r.c)
            CMD_PROGRESS:
              if (tbl_status[i] == ST_READING) begin
                sum = {1'b0, tbl_bytes[i]} + 33'(r.cnt);
                tbl_bytes[i] = sum[32] ? BYTES_MAX : sum[31:0];
              end
            CMD_FINISH:
              if (tbl_status[i] == ST_READING) begin
                if (r.oc != 0) post_completion(i, ST_FAILED, 3'(r.oc));
                else if (tbl_bytes[i] == tbl_size[i]) post_completion(i, ST_READY, RC_OK);
                else post_completion(i, ST_FAILED, RC_SHORT);
              end
            CMD_CANCEL:
              if (tbl_status[i] != ST_READY && tbl_status[i] != ST_FAILED &&
                  tbl_status[i] != ST_CANCELLED)
                post_completion(i, ST_CANCELLED, RC_CANCELLED);
            CMD_RELEASE:
              if (tbl_status[i] != ST_READING) clear_entry(i);
            default: ;
          endcase
          push_slot(i, tbl_status[i], 0, 1);
        end
      end
    endcase
  endfunction

  function automatic cmd_row_t row(cmd_t c, logic [15:0] idx, logic [15:0] gen,
                                   logic [31:0] offset, logic [31:0] size,
                                   logic [2:0] pri, logic [31:0] tag,
                                   logic [16:0] cnt, logic [1:0] oc);
    cmd_row_t r;
    r.c = c; r.idx = idx; r.gen = gen; r.offset = offset; r.size = size;
    r.pri = pri; r.tag = tag; r.cnt = cnt; r.oc = oc;
    r.set_en = -1; r.typed = 0;
    r.found = 0; r.slot = NO_SLOT; r.status = ST_UNUSED; r.rc = RC_OK;
    return r;
  endfunction

  function automatic cmd_row_t typed(cmd_row_t r, logic f, logic [15:0] s,
                                     logic [2:0] st, logic [2:0] rc);
    r.typed = 1; r.found = f; r.slot = s; r.status = st; r.rc = rc;
    return r;
  endfunction

  function automatic cmd_row_t enable_row(int v);
    cmd_row_t r;
    r = row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
    r.set_en = v;
    return r;
  endfunction

  // random command; handles mostly point at live slots
  function automatic cmd_row_t random_cmd(bit submit_only);
    cmd_row_t r;
    int       k;
    int       s;
    int       j;
    int       mode;
    cmd_t     c;
    k = submit_only ? 0 : $urandom_range(0, 99);
    if (k < 25) c = CMD_SUBMIT;
    else if (k < 40) c = CMD_CLAIM;
    else if (k < 60) c = CMD_PROGRESS;
    else if (k < 75) c = CMD_FINISH;
    else if (k < 83) c = CMD_CANCEL;
    else if (k < 92) c = CMD_RELEASE;
    else if (k < 96) c = CMD_QUERY;
    else c = CMD_DISPATCH;
    s = $urandom_range(0, SLOTS - 1);
    for (j = 0; j < SLOTS; j++)
      if (tbl_used[(s + j) % SLOTS]) begin
        s = (s + j) % SLOTS;
        break;
      end
    r = row(c, 16'(s), tbl_gen[s], 32'($urandom), 32'd0, 3'($urandom_range(0, 7)),
            32'($urandom), 17'd0, 2'd0);
    mode = $urandom_range(0, 9);
    if (mode == 7) r.gen = tbl_gen[s] + 16'd1;
    else if (mode == 8) begin
      r.idx = 16'($urandom_range(SLOTS, 65535));
      r.gen = 16'($urandom);
    end else if (mode == 9) begin
      r.idx = 16'($urandom);
      r.gen = 16'($urandom);
    end
    if (submit_only) r.size = 32'($urandom_range(1, 6));
    else r.size = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 6));
    r.cnt = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(0, 65536))
                                        : 17'($urandom_range(0, 6));
    r.oc = ($urandom_range(0, 1) == 0) ? 2'd0 : 2'($urandom);
    return r;
  endfunction

  task automatic set_enable(int v);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_en = v[0];
  endtask

  task automatic send_cmd(cmd_row_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= r.c;
    slot_index <= r.idx;
    handle_generation <= r.gen;
    req_offset <= r.offset;
    req_size <= r.size;
    priority_req <= r.pri;
    user_tag <= r.tag;
    byte_count <= r.cnt;
    io_outcome <= r.oc;
    do @(posedge clk); while (!in_ready);
    table_step(r);
    if (r.typed) begin
      expected_beats[expected_beats.size() - 1].found = r.found;
      expected_beats[expected_beats.size() - 1].slot = r.slot;
      expected_beats[expected_beats.size() - 1].status = r.status;
      expected_beats[expected_beats.size() - 1].rc = r.rc;
    end
  endtask

  // receiver: random stalls per beat, one long hold-off on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h got %h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    beat_t b;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, slot %h", $time, out_slot);
        errors++;
      end else begin
        b = expected_beats.pop_front();
        check_field("found", b.found, found);
        check_field("out_slot", b.slot, out_slot);
        check_field("out_generation", b.gen, out_generation);
        check_field("out_status", b.status, out_status);
        check_field("result_code", b.rc, result_code);
        check_field("bytes_done", b.bytes, bytes_done);
        check_field("out_tag", b.tag, out_tag);
        check_field("out_offset", b.offset, out_offset);
        check_field("out_size", b.size, out_size);
        check_field("abort_transfer", b.abort, abort_transfer);
        check_field("last", b.last, last);
      end
    end
  end

  initial begin
    int n;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid <= 1'b0;
    command <= CMD_SUBMIT;
    slot_index <= '0;
    handle_generation <= '0;
    req_offset <= '0;
    req_size <= '0;
    priority_req <= '0;
    user_tag <= '0;
    byte_count <= '0;
    io_outcome <= '0;
    tbl_en = 0;
    for (n = 0; n < SLOTS; n++) begin
      clear_entry(n);
      tbl_gen[n] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_enable(0);

    // directed: disabled table, then one life cycle of a few requests
    cmd_rows.push_back(typed(row(CMD_SUBMIT, 0, 0, 0, 1, 0, 0, 0, 0),
                             0, NO_SLOT, ST_UNUSED, RC_OK));
    cmd_rows.push_back(typed(row(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, NO_SLOT, ST_UNUSED, RC_OK));
    cmd_rows.push_back(typed(row(CMD_CLAIM, 0, 0, 0, 0, 0, 0, 0, 0),
                             0, NO_SLOT, ST_UNUSED, RC_OK));
    cmd_rows.push_back(typed(row(CMD_PROGRESS, 0, 0, 0, 0, 0, 0, 17'd65536, 0),
                             0, NO_SLOT, ST_UNUSED, RC_OK));
    cmd_rows.push_back(enable_row(1));
    cmd_rows.push_back(typed(row(CMD_SUBMIT, 0, 0, 32'hffff_ffff, 0, 7, 1, 0, 0),
                             0, NO_SLOT, ST_UNUSED, RC_OK));
    cmd_rows.push_back(typed(row(CMD_SUBMIT, 16'hffff, 16'hffff, 32'hffff_ffff,
                                 32'hffff_ffff, 7, 32'hffff_ffff, 17'h1ffff, 2'd3),
                             1, 0, ST_QUEUED, RC_OK));
    cmd_rows.push_back(row(CMD_SUBMIT, 0, 0, 0, 3, 0, 0, 0, 0));
    cmd_rows.push_back(row(CMD_SUBMIT, 0, 0, 32'h5a, 8, 7, 32'ha5a5, 0, 0));
    cmd_rows.push_back(typed(row(CMD_CLAIM, 0, 0, 0, 0, 0, 0, 0, 0),
                             1, 0, ST_READING, RC_OK));
    cmd_rows.push_back(row(CMD_PROGRESS, 0, 1, 0, 0, 0, 0, 17'd65536, 0));
    cmd_rows.push_back(row(CMD_PROGRESS, 0, 1, 0, 0, 0, 0, 17'd1, 0));
    cmd_rows.push_back(typed(row(CMD_FINISH, 0, 1, 0, 0, 0, 0, 0, 0),
                             1, 0, ST_FAILED, RC_SHORT));
    cmd_rows.push_back(row(CMD_CLAIM, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_rows.push_back(typed(row(CMD_FINISH, 2, 1, 0, 0, 0, 0, 0, 2'd3),
                             1, 2, ST_FAILED, 3'd3));
    cmd_rows.push_back(typed(row(CMD_CANCEL, 1, 1, 0, 0, 0, 0, 0, 0),
                             1, 1, ST_CANCELLED, RC_CANCELLED));
    cmd_rows.push_back(row(CMD_PROGRESS, 1, 1, 0, 0, 0, 0, 17'd5, 0));
    cmd_rows.push_back(row(CMD_CANCEL, 1, 1, 0, 0, 0, 0, 0, 0));
    cmd_rows.push_back(row(CMD_FINISH, 1, 1, 0, 0, 0, 0, 0, 2'd1));
    cmd_rows.push_back(typed(row(CMD_QUERY, 20, 1, 0, 0, 0, 0, 0, 0),
                             0, NO_SLOT, ST_UNUSED, RC_OK));
    cmd_rows.push_back(row(CMD_QUERY, 1, 2, 0, 0, 0, 0, 0, 0));
    cmd_rows.push_back(typed(row(CMD_RELEASE, 2, 1, 0, 0, 0, 0, 0, 0),
                             1, 2, ST_UNUSED, RC_OK));
    cmd_rows.push_back(row(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_rows.push_back(row(CMD_RELEASE, 0, 1, 0, 0, 0, 0, 0, 0));
    cmd_rows.push_back(row(CMD_SUBMIT, 0, 0, 32'h10, 3, 3, 32'h77, 0, 0));
    cmd_rows.push_back(row(CMD_CLAIM, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_rows.push_back(row(CMD_PROGRESS, 0, 2, 0, 0, 0, 0, 17'd3, 0));
    cmd_rows.push_back(row(CMD_RELEASE, 0, 2, 0, 0, 0, 0, 0, 0));
    cmd_rows.push_back(typed(row(CMD_FINISH, 0, 2, 0, 0, 0, 0, 0, 0),
                             1, 0, ST_READY, RC_OK));
    cmd_rows.push_back(row(CMD_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0));

    foreach (cmd_rows[k]) begin
      if (cmd_rows[k].set_en >= 0) set_enable(cmd_rows[k].set_en);
      else send_cmd(cmd_rows[k]);
    end

    // random: enabled, then disabled, then fill the table and push hard
    for (n = 0; n < 30; n++) send_cmd(random_cmd(0));
    set_enable(0);
    for (n = 0; n < 15; n++) send_cmd(random_cmd(0));
    set_enable(1);
    for (n = 0; n < SLOTS + 2; n++) send_cmd(random_cmd(1));
    for (n = 0; n < 30; n++) begin
      if (n == 10) long_hold = 1;
      calm = (n >= 20 && n < 28);
      send_cmd(random_cmd(0));
    end
    calm = 0;

    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (errors == 0)
      $display("prioritized_request_slot_table_unit_tb OK");
    else
      $display("prioritized_request_slot_table_unit_tb NOT OK");
    $finish;
  end
endmodule
